FILE: hdl/soi_pkg.sv
// Shared types, constants and helpers for the sparse octree point index.
// No dependencies; used by soi_ctrl, soi_dpath and the top level under hdl.
package soi_pkg;

	localparam int COORD_W    = 4;
	localparam int POINT_W    = 12;
	localparam int CHILD_CNT  = 8;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_FULL = 2'd1,
		RES_HIT  = 2'd2
	} res_t;

	typedef struct packed {
		logic load_item;
		logic clear_store;
		logic split_node;
		logic fill_write;
		logic step_down;
		logic load_mem;
		logic write_point;
		logic out_load;
		res_t res;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    at_depth;
		logic    cur_leaf;
		logic    cur_empty;
		logic    no_room;
		logic    fill_last;
		logic    out_free;
	} status_t;

	// fixed child ordering
	function automatic logic [2:0] child_perm(input logic [2:0] sel);
		logic [2:0] r;
		case (sel)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd3;
			3'd3: r = 3'd7;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd2;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

	// bit s of each coordinate, zero above the coordinate width
	function automatic logic [2:0] child_slot(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z, input logic [2:0] s);
		logic [2:0] sel;
		sel = 3'd0;
		if (s < 3'(COORD_W)) begin
			sel = {z[s[1:0]], y[s[1:0]], x[s[1:0]]};
		end
		return child_perm(sel);
	endfunction

endpackage

FILE: hdl/soi_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module soi_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/soi_ctrl.sv
// Sequencing state machine for clear, insert and lookup requests.
// Depends on soi_pkg; drives soi_dpath through cmd_t and reads status_t.
module soi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  soi_pkg::status_t sts,
	output soi_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_ROUTE  = 7'b0000010,
		ST_EVAL   = 7'b0000100,
		ST_FILL   = 7'b0001000,
		ST_STEP   = 7'b0010000,
		ST_LOAD   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	soi_pkg::res_t res_q, res_d;
	logic          accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					res_d         = soi_pkg::RES_ZERO;
					state_d       = ST_ROUTE;
				end
			end
			// the action is latched at accept; route on it in the cycle after
			ST_ROUTE: begin
				unique case (sts.act) inside
					soi_pkg::ACT_CLEAR: begin
						cmd.clear_store = 1'b1;
						state_d         = ST_FINISH;
					end
					soi_pkg::ACT_INSERT, soi_pkg::ACT_LOOKUP: begin
						state_d = ST_EVAL;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_EVAL: begin
				if (sts.act == soi_pkg::ACT_INSERT) begin
					if (sts.at_depth) begin
						cmd.write_point = 1'b1;
						res_d           = soi_pkg::RES_ZERO;
						state_d         = ST_FINISH;
					end else if (sts.cur_leaf) begin
						if (sts.no_room) begin
							res_d   = soi_pkg::RES_FULL;
							state_d = ST_FINISH;
						end else begin
							cmd.split_node = 1'b1;
							state_d        = ST_FILL;
						end
					end else begin
						state_d = ST_STEP;
					end
				end else begin
					if (sts.cur_empty) begin
						res_d   = soi_pkg::RES_ZERO;
						state_d = ST_FINISH;
					end else if (sts.cur_leaf) begin
						res_d   = soi_pkg::RES_HIT;
						state_d = ST_FINISH;
					end else if (sts.at_depth) begin
						res_d   = soi_pkg::RES_ZERO;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_STEP;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_write = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step_down = 1'b1;
				state_d       = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_mem = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q   <= soi_pkg::RES_ZERO;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

FILE: hdl/soi_dpath.sv
// Datapath: request latch, current node, bump allocator, node RAM, result register.
// Depends on soi_pkg and soi_ram.
module soi_dpath #(
	parameter int GRID_SIZE     = 16,
	parameter int NODE_CAPACITY = 8192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  soi_pkg::cmd_t                  cmd,
	output soi_pkg::status_t               sts,
	input  logic [1:0]                     action,
	input  logic [soi_pkg::COORD_W-1:0]    x_coord,
	input  logic [soi_pkg::COORD_W-1:0]    y_coord,
	input  logic [soi_pkg::COORD_W-1:0]    z_coord,
	input  logic [soi_pkg::POINT_W-1:0]    point_index,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic                           found,
	output logic [soi_pkg::POINT_W-1:0]    point_out,
	output logic                           store_full
);

	localparam int TREE_DEPTH = $clog2(GRID_SIZE);
	localparam int LVL_W      = $clog2(TREE_DEPTH + 1);
	localparam int IDX_W      = $clog2(NODE_CAPACITY);
	localparam int NF_W       = $clog2(NODE_CAPACITY + 1);
	localparam int NIDX_W     = (IDX_W > soi_pkg::POINT_W) ? IDX_W : soi_pkg::POINT_W;
	localparam int NODE_W     = NIDX_W + 2;

	soi_pkg::action_t            act_q;
	logic [soi_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic [soi_pkg::POINT_W-1:0] pt_q;

	logic              root_split_q;
	logic [NF_W-1:0]   next_free_q;
	logic              cur_leaf_q, cur_empty_q, cur_root_q;
	logic [NIDX_W-1:0] cur_index_q;
	logic [IDX_W-1:0]  cur_addr_q;
	logic [LVL_W-1:0]  level_q;
	logic [2:0]        fill_cnt_q;

	logic              out_valid_q, found_q, full_q;
	logic [soi_pkg::POINT_W-1:0] point_q;

	logic [2:0]        shift_sel;
	logic [2:0]        slot;
	logic [IDX_W-1:0]  child_addr;
	logic [IDX_W-1:0]  fill_addr;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [NODE_W-1:0] ram_wdata, ram_rdata;

	assign shift_sel  = 3'(TREE_DEPTH - 1) - 3'(level_q);
	assign slot       = soi_pkg::child_slot(x_q, y_q, z_q, shift_sel);
	assign child_addr = cur_index_q[IDX_W-1:0] + IDX_W'(slot);
	assign fill_addr  = cur_index_q[IDX_W-1:0] + IDX_W'(fill_cnt_q);

	// node word: leaf, empty, index
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = child_addr;
		ram_wdata = {1'b1, 1'b1, NIDX_W'(0)};
		if (cmd.split_node && !cur_root_q) begin
			ram_we    = 1'b1;
			ram_addr  = cur_addr_q;
			ram_wdata = {1'b0, 1'b0, NIDX_W'(next_free_q)};
		end else if (cmd.fill_write) begin
			ram_we    = 1'b1;
			ram_addr  = fill_addr;
		end else if (cmd.write_point) begin
			ram_we    = 1'b1;
			ram_addr  = cur_addr_q;
			ram_wdata = {1'b1, 1'b0, NIDX_W'(pt_q)};
		end
	end

	soi_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODE_CAPACITY)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q <= soi_pkg::action_t'(action);
			x_q   <= x_coord;
			y_q   <= y_coord;
			z_q   <= z_coord;
			pt_q  <= point_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_split_q <= 1'b0;
			next_free_q  <= NF_W'(1);
			cur_leaf_q   <= 1'b1;
			cur_empty_q  <= 1'b1;
			cur_root_q   <= 1'b1;
			cur_index_q  <= '0;
			cur_addr_q   <= '0;
			level_q      <= '0;
			fill_cnt_q   <= '0;
		end else begin
			if (cmd.clear_store) begin
				root_split_q <= 1'b0;
				next_free_q  <= NF_W'(1);
			end
			if (cmd.load_item) begin
				// root lives in flops: empty leaf, or split with children at one
				cur_leaf_q  <= !root_split_q;
				cur_empty_q <= !root_split_q;
				cur_root_q  <= 1'b1;
				cur_index_q <= NIDX_W'(1);
				cur_addr_q  <= '0;
				level_q     <= '0;
			end
			if (cmd.split_node) begin
				if (cur_root_q) begin
					root_split_q <= 1'b1;
				end
				cur_index_q <= NIDX_W'(next_free_q);
				next_free_q <= next_free_q + NF_W'(soi_pkg::CHILD_CNT);
				fill_cnt_q  <= '0;
			end
			if (cmd.fill_write) begin
				fill_cnt_q <= fill_cnt_q + 3'd1;
			end
			if (cmd.step_down) begin
				cur_addr_q <= child_addr;
				cur_root_q <= 1'b0;
				level_q    <= level_q + LVL_W'(1);
			end
			if (cmd.load_mem) begin
				cur_leaf_q  <= ram_rdata[NODE_W-1];
				cur_empty_q <= ram_rdata[NODE_W-2];
				cur_index_q <= ram_rdata[NIDX_W-1:0];
			end
		end
	end

	// result register, frees the request side while a response waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q <= (cmd.res == soi_pkg::RES_HIT);
			full_q  <= (cmd.res == soi_pkg::RES_FULL);
			point_q <= (cmd.res == soi_pkg::RES_HIT) ? cur_index_q[soi_pkg::POINT_W-1:0] : '0;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign found      = found_q;
	assign point_out  = point_q;
	assign store_full = full_q;

	assign sts.act       = act_q;
	assign sts.at_depth  = (level_q == LVL_W'(TREE_DEPTH));
	assign sts.cur_leaf  = cur_leaf_q;
	assign sts.cur_empty = cur_empty_q;
	assign sts.no_room   = (next_free_q > NF_W'(NODE_CAPACITY - soi_pkg::CHILD_CNT));
	assign sts.fill_last = (fill_cnt_q == 3'(soi_pkg::CHILD_CNT - 1));
	assign sts.out_free  = !out_valid_q || !rsp_stall;

endmodule

FILE: hdl/sparse_octree_point_index_core.sv
// Top level of the sparse octree point index.
// Depends on soi_pkg, soi_ctrl, soi_dpath (and soi_ram below it).
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------------
//   request | req_valid | req_stall | action, x_coord, y_coord, z_coord, point_index
//   result  | rsp_valid | rsp_stall | found, point_out, store_full
//
// One request at a time. Clear and no-op go from route straight to finish; a lookup or
// insert evaluates the current node, then steps down and loads the child for each
// level it descends. An insert that splits a leaf first writes the eight children,
// one per cycle through the single-port node RAM.
// Reset leaves the root as an empty leaf in flops; the node RAM needs no clearing.
// A finished result waits in an output register, so the next request is taken
// while rsp_stall is high.
module sparse_octree_point_index_core #(
	parameter int GRID_SIZE     = 16,
	parameter int NODE_CAPACITY = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  action,
	input  logic [soi_pkg::COORD_W-1:0] x_coord,
	input  logic [soi_pkg::COORD_W-1:0] y_coord,
	input  logic [soi_pkg::COORD_W-1:0] z_coord,
	input  logic [soi_pkg::POINT_W-1:0] point_index,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        found,
	output logic [soi_pkg::POINT_W-1:0] point_out,
	output logic                        store_full
);

	soi_pkg::cmd_t    cmd;
	soi_pkg::status_t sts;

	soi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	soi_dpath #(
		.GRID_SIZE     (GRID_SIZE),
		.NODE_CAPACITY (NODE_CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.point_index (point_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.found       (found),
		.point_out   (point_out),
		.store_full  (store_full)
	);

endmodule

FILE: verif/tb_sparse_octree_point_index_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for sparse_octree_point_index_core: insert, lookup and clear traffic
// checked against an in-bench octree predictor. Depends on soi_pkg and the core RTL only.
module tb_sparse_octree_point_index_core;

	localparam int GRID_SIZE     = 16;
	localparam int NODES         = 8192;
	localparam int TREE_LEVELS   = $clog2(GRID_SIZE);
	localparam int PHASE_ITEMS   = 630;
	localparam int SETTLE_CYCLES = 64;

	// octant order used when choosing a child
	localparam logic [2:0] OCTANT_ORDER [soi_pkg::CHILD_CNT] = '{3'd0, 3'd4, 3'd3, 3'd7,
		3'd1, 3'd5, 3'd2, 3'd6};

	typedef struct packed {
		logic                        hit;
		logic [soi_pkg::POINT_W-1:0] pt;
		logic                        full;
	} cell_result_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        req_valid   = 1'b0;
	logic                        req_stall;
	logic [1:0]                  action      = soi_pkg::ACT_NOP;
	logic [soi_pkg::COORD_W-1:0] x_coord     = '0;
	logic [soi_pkg::COORD_W-1:0] y_coord     = '0;
	logic [soi_pkg::COORD_W-1:0] z_coord     = '0;
	logic [soi_pkg::POINT_W-1:0] point_index = '0;
	logic                        rsp_valid;
	logic                        rsp_stall   = 1'b0;
	logic                        found;
	logic [soi_pkg::POINT_W-1:0] point_out;
	logic                        store_full;

	// predictor copy of the tree
	logic        nd_leaf  [NODES];
	logic        nd_empty [NODES];
	int unsigned nd_index [NODES];
	int unsigned next_free;

	cell_result_t                  pending_results [$];
	logic [3*soi_pkg::COORD_W-1:0] known_cells [$];
	int                            fault_count    = 0;
	int                            send_idle_pct  = 0;
	int                            recv_idle_pct  = 0;

	sparse_octree_point_index_core #(
		.GRID_SIZE    (GRID_SIZE),
		.NODE_CAPACITY(NODES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.point_index(point_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found      (found),
		.point_out  (point_out),
		.store_full (store_full)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic void clear_tree();
		nd_leaf[0]  = 1'b1;
		nd_empty[0] = 1'b1;
		nd_index[0] = 0;
		next_free   = 1;
	endfunction

	function automatic logic [2:0] octant(input logic [soi_pkg::COORD_W-1:0] x, y, z,
		input int level);
		logic [1:0] sh;
		sh = 2'(TREE_LEVELS - level - 1);
		return OCTANT_ORDER[{z[sh], y[sh], x[sh]}];
	endfunction

	// Applies one request to the predictor tree and returns the result it should give.
	function automatic cell_result_t apply_request(input soi_pkg::action_t act,
		input logic [soi_pkg::COORD_W-1:0] x, y, z, input logic [soi_pkg::POINT_W-1:0] pt);
		cell_result_t r;
		int unsigned node;
		int level;
		r = '0;
		node = 0;
		level = 0;
		case (act)
			soi_pkg::ACT_CLEAR: begin
				clear_tree();
			end
			soi_pkg::ACT_INSERT: begin
				while (level < TREE_LEVELS) begin
					if (nd_leaf[node]) begin
						// no room for eight more children: drop, earlier splits stay
						if (next_free > NODES - soi_pkg::CHILD_CNT) begin
							r.full = 1'b1;
							break;
						end
						nd_leaf[node]  = 1'b0;
						nd_empty[node] = 1'b0;
						nd_index[node] = next_free;
						for (int i = 0; i < soi_pkg::CHILD_CNT; i++) begin
							nd_leaf[next_free + i]  = 1'b1;
							nd_empty[next_free + i] = 1'b1;
							nd_index[next_free + i] = 0;
						end
						next_free += soi_pkg::CHILD_CNT;
					end
					node = nd_index[node] + octant(x, y, z, level);
					if (node >= NODES) begin
						r.full = 1'b1;
						break;
					end
					level++;
				end
				if (!r.full) begin
					nd_leaf[node]  = 1'b1;
					nd_empty[node] = 1'b0;
					nd_index[node] = 32'(pt);
				end
			end
			soi_pkg::ACT_LOOKUP: begin
				while (1) begin
					if (nd_empty[node]) break;
					if (nd_leaf[node]) begin
						r.hit = 1'b1;
						r.pt  = nd_index[node][soi_pkg::POINT_W-1:0];
						break;
					end
					if (level >= TREE_LEVELS) break;
					node = nd_index[node] + octant(x, y, z, level);
					if (node >= NODES) break;
					level++;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Leaves req_valid high on return so a back-to-back request needs no toggle.
	task automatic send_request(input soi_pkg::action_t act,
		input logic [soi_pkg::COORD_W-1:0] x, y, z, input logic [soi_pkg::POINT_W-1:0] pt);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid   <= 1'b1;
		action      <= act;
		x_coord     <= x;
		y_coord     <= y;
		z_coord     <= z;
		point_index <= pt;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(apply_request(act, x, y, z, pt));
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing outstanding: found %0b point_out %0d full %0b",
					$time, found, point_out, store_full);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.hit) begin
					$display("%0t: found expected %0b actual %0b", $time, want.hit, found);
					fault_count++;
				end
				if (point_out !== want.pt) begin
					$display("%0t: point_out expected %0d actual %0d", $time, want.pt, point_out);
					fault_count++;
				end
				if (store_full !== want.full) begin
					$display("%0t: store_full expected %0b actual %0b", $time, want.full,
						store_full);
					fault_count++;
				end
			end
		end
	end

	task automatic test_empty_tree();
		send_request(soi_pkg::ACT_LOOKUP, 4'd0, 4'd0, 4'd0, 12'd0);
		send_request(soi_pkg::ACT_LOOKUP, 4'd15, 4'd15, 4'd15, 12'hFFF);
		send_request(soi_pkg::ACT_NOP, 4'd15, 4'd15, 4'd15, 12'hFFF);
	endtask

	task automatic test_insert_overwrite();
		send_request(soi_pkg::ACT_INSERT, 4'd0, 4'd0, 4'd0, 12'd0);
		send_request(soi_pkg::ACT_INSERT, 4'd15, 4'd15, 4'd15, 12'hFFF);
		send_request(soi_pkg::ACT_LOOKUP, 4'd0, 4'd0, 4'd0, 12'hFFF);
		send_request(soi_pkg::ACT_LOOKUP, 4'd15, 4'd15, 4'd15, 12'd0);
		// sibling leaf still empty, then a miss one level below a split node
		send_request(soi_pkg::ACT_LOOKUP, 4'd1, 4'd0, 4'd0, 12'd0);
		send_request(soi_pkg::ACT_LOOKUP, 4'd8, 4'd8, 4'd8, 12'd0);
		send_request(soi_pkg::ACT_INSERT, 4'd15, 4'd15, 4'd15, 12'hAAA);
		send_request(soi_pkg::ACT_LOOKUP, 4'd15, 4'd15, 4'd15, 12'd0);
		send_request(soi_pkg::ACT_INSERT, 4'd10, 4'd5, 4'd10, 12'h555);
		send_request(soi_pkg::ACT_LOOKUP, 4'd10, 4'd5, 4'd10, 12'd0);
		send_request(soi_pkg::ACT_INSERT, 4'd5, 4'd10, 4'd5, 12'h123);
		send_request(soi_pkg::ACT_NOP, 4'd0, 4'd0, 4'd0, 12'd0);
	endtask

	task automatic test_clear();
		send_request(soi_pkg::ACT_CLEAR, 4'd0, 4'd0, 4'd0, 12'd0);
		send_request(soi_pkg::ACT_LOOKUP, 4'd15, 4'd15, 4'd15, 12'd0);
		send_request(soi_pkg::ACT_LOOKUP, 4'd0, 4'd0, 4'd0, 12'd0);
		send_request(soi_pkg::ACT_INSERT, 4'd3, 4'd12, 4'd9, 12'h7FF);
		send_request(soi_pkg::ACT_LOOKUP, 4'd3, 4'd12, 4'd9, 12'd0);
		send_request(soi_pkg::ACT_CLEAR, 4'd15, 4'd15, 4'd15, 12'hFFF);
		send_request(soi_pkg::ACT_LOOKUP, 4'd3, 4'd12, 4'd9, 12'd0);
	endtask

	// Mostly inserts and lookups over cells already written, so lookups walk deep and
	// inserts overwrite; clears and unused codes are mixed in sparsely. With a 16-cell grid
	// the full tree is 4681 nodes, so node capacity never runs out.
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		logic [3*soi_pkg::COORD_W-1:0] coord_sel;
		int roll;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			roll = $urandom_range(99);
			coord_sel = (3*soi_pkg::COORD_W)'($urandom_range(4095));
			if (known_cells.size() != 0 && $urandom_range(99) < 60) begin
				coord_sel = known_cells[$urandom_range(known_cells.size() - 1)];
			end
			if (roll < 1) begin
				known_cells.delete();
				send_request(soi_pkg::ACT_CLEAR, coord_sel[11:8], coord_sel[7:4],
					coord_sel[3:0], soi_pkg::POINT_W'($urandom_range(4095)));
			end else if (roll < 5) begin
				send_request(soi_pkg::ACT_NOP, coord_sel[11:8], coord_sel[7:4],
					coord_sel[3:0], soi_pkg::POINT_W'($urandom_range(4095)));
			end else if (roll < 50) begin
				known_cells.push_back(coord_sel);
				send_request(soi_pkg::ACT_INSERT, coord_sel[11:8], coord_sel[7:4],
					coord_sel[3:0], soi_pkg::POINT_W'($urandom_range(4095)));
			end else begin
				send_request(soi_pkg::ACT_LOOKUP, coord_sel[11:8], coord_sel[7:4],
					coord_sel[3:0], soi_pkg::POINT_W'($urandom_range(4095)));
			end
		end
		wait_results_drained();
	endtask

	initial begin
		clear_tree();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 18;
		recv_idle_pct = 73;
		test_empty_tree();
		test_insert_overwrite();
		test_clear();
		// hold requests back until the pipeline is empty
		wait_results_drained();
		test_random_traffic(18, 73);
		test_random_traffic(73, 18);
		test_random_traffic(0, 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/soi_pkg.sv
hdl/soi_ram.sv
hdl/soi_ctrl.sv
hdl/soi_dpath.sv
hdl/sparse_octree_point_index_core.sv
verif/tb_sparse_octree_point_index_core.sv
